### rtl/mftt_pkg.sv
// ----------------------------------------------------------------------------
// Motor feedback turn tracker package
// Shared constants, controller states and the controller/datapath interface.
// ----------------------------------------------------------------------------
package mftt_pkg;

	localparam int MOTORS_PER_BUS_DEF = 8;
	localparam int BUS_COUNT_DEF      = 3;

	localparam int BUS_W    = 2;
	localparam int FID_W    = 11;
	localparam int PAYLOAD_W = 56;
	localparam int SLOT_OUT_W = 3;
	localparam int ANGLE_W  = 16;
	localparam int SPEED_W  = 16;
	localparam int CURR_W   = 16;
	localparam int TEMP_W   = 8;
	localparam int TURN_W   = 32;
	localparam int THR_W    = 16;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 1;

	localparam logic [FID_W-1:0] BASE_FRAME_ID_RST  = 11'd513;
	localparam logic [THR_W-1:0] WRAP_THRESHOLD_RST = 16'd5000;

	localparam logic [CFG_IDX_W-1:0] CFG_BASE_FRAME_ID  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WRAP_THRESHOLD = 1'd1;

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_LOOKUP = 3'b010,
		S_UPDATE = 3'b100
	} state_t;

	typedef struct packed {
		logic capture;
		logic lookup;
		logic update;
	} ctrl_cmd_t;

	typedef struct packed {
		logic hit;
	} dp_status_t;

endpackage

### rtl/mftt_ctrl.sv
// ----------------------------------------------------------------------------
// Motor feedback turn tracker controller
// Sequences capture, slot table lookup and update for one request at a time.
// ----------------------------------------------------------------------------
module mftt_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  mftt_pkg::dp_status_t  status,
	output mftt_pkg::ctrl_cmd_t   cmd,
	output logic                  busy
);

	mftt_pkg::state_t state_q;
	mftt_pkg::state_t state_nxt;

	always_comb begin
		state_nxt   = state_q;
		cmd.capture = 1'b0;
		cmd.lookup  = 1'b0;
		cmd.update  = 1'b0;
		unique case (state_q)
			mftt_pkg::S_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_nxt   = mftt_pkg::S_LOOKUP;
				end
			end
			mftt_pkg::S_LOOKUP: begin
				cmd.lookup = 1'b1;
				// drop requests that miss the bus range or the identifier window
				state_nxt  = status.hit ? mftt_pkg::S_UPDATE : mftt_pkg::S_IDLE;
			end
			mftt_pkg::S_UPDATE: begin
				cmd.update = 1'b1;
				state_nxt  = mftt_pkg::S_IDLE;
			end
			default: begin
				state_nxt = mftt_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mftt_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign busy = (state_q != mftt_pkg::S_IDLE);

endmodule

### rtl/mftt_dp.sv
// ----------------------------------------------------------------------------
// Motor feedback turn tracker datapath
// Config registers, frame decode, slot table and turn counter update.
// ----------------------------------------------------------------------------
module mftt_dp #(
	parameter int MOTORS_PER_BUS = mftt_pkg::MOTORS_PER_BUS_DEF,
	parameter int BUS_COUNT      = mftt_pkg::BUS_COUNT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  mftt_pkg::ctrl_cmd_t                 cmd,
	output mftt_pkg::dp_status_t                status,
	input  logic                                cfg_we,
	input  logic [mftt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mftt_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic [mftt_pkg::BUS_W-1:0]          bus_number,
	input  logic [mftt_pkg::FID_W-1:0]          frame_id,
	input  logic [mftt_pkg::PAYLOAD_W-1:0]      payload,
	output logic                                done,
	output logic [mftt_pkg::BUS_W-1:0]          bus_out,
	output logic [mftt_pkg::SLOT_OUT_W-1:0]     motor_slot,
	output logic [mftt_pkg::ANGLE_W-1:0]        angle,
	output logic [mftt_pkg::ANGLE_W-1:0]        previous_angle,
	output logic signed [mftt_pkg::SPEED_W-1:0] speed,
	output logic signed [mftt_pkg::CURR_W-1:0]  current,
	output logic [mftt_pkg::TEMP_W-1:0]         temperature,
	output logic signed [mftt_pkg::TURN_W-1:0]  turn_count
);

	localparam int DEPTH  = MOTORS_PER_BUS * BUS_COUNT;
	localparam int SLOT_W = (MOTORS_PER_BUS > 1) ? $clog2(MOTORS_PER_BUS) : 1;
	localparam int POS_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int ENTRY_W = mftt_pkg::ANGLE_W + mftt_pkg::TURN_W;
	localparam int DIFF_W = mftt_pkg::ANGLE_W + 2;

	// config registers
	logic [mftt_pkg::FID_W-1:0] base_q;
	logic [mftt_pkg::THR_W-1:0] thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= mftt_pkg::BASE_FRAME_ID_RST;
			thr_q  <= mftt_pkg::WRAP_THRESHOLD_RST;
		end else if (cfg_we) begin
			if (cfg_index == mftt_pkg::CFG_BASE_FRAME_ID) begin
				base_q <= cfg_data[mftt_pkg::FID_W-1:0];
			end
			if (cfg_index == mftt_pkg::CFG_WRAP_THRESHOLD) begin
				thr_q <= cfg_data[mftt_pkg::THR_W-1:0];
			end
		end
	end

	// window decode of the incoming request
	logic [mftt_pkg::FID_W-1:0] offset;
	logic                       hit_c;
	logic [SLOT_W-1:0]          slot_c;
	logic [POS_W-1:0]           pos_c;

	assign offset = frame_id - base_q;
	assign hit_c  = ({1'b0, bus_number} < 3'(BUS_COUNT)) && (frame_id >= base_q)
		&& (offset < mftt_pkg::FID_W'(MOTORS_PER_BUS));
	assign slot_c = offset[SLOT_W-1:0];
	assign pos_c  = POS_W'(int'(bus_number) * MOTORS_PER_BUS + int'(slot_c));

	logic                                hit_q;
	logic [POS_W-1:0]                    pos_q;
	logic [mftt_pkg::BUS_W-1:0]          bus_q;
	logic [mftt_pkg::SLOT_OUT_W-1:0]     slot_q;
	logic [mftt_pkg::ANGLE_W-1:0]        angle_q;
	logic [mftt_pkg::SPEED_W-1:0]        speed_q;
	logic [mftt_pkg::CURR_W-1:0]         curr_q;
	logic [mftt_pkg::TEMP_W-1:0]         temp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (cmd.capture) begin
			hit_q <= hit_c;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			pos_q   <= pos_c;
			bus_q   <= bus_number;
			slot_q  <= offset[mftt_pkg::SLOT_OUT_W-1:0];
			angle_q <= payload[55:40];
			speed_q <= payload[39:24];
			curr_q  <= payload[23:8];
			temp_q  <= payload[7:0];
		end
	end

	assign status.hit = hit_q;

	// slot table: {angle, turn count}, valid bits stand in for the zero reset
	logic [ENTRY_W-1:0] mem_q [DEPTH];
	logic [DEPTH-1:0]   valid_q;
	logic [ENTRY_W-1:0] rd_data_q;
	logic               rd_valid_q;
	logic [ENTRY_W-1:0] wr_data;

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			mem_q[pos_q] <= wr_data;
		end
		if (cmd.lookup) begin
			rd_data_q <= mem_q[pos_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (cmd.update) begin
				valid_q[pos_q] <= 1'b1;
			end
			if (cmd.lookup) begin
				rd_valid_q <= valid_q[pos_q];
			end
		end
	end

	// turn counter update
	logic [mftt_pkg::ANGLE_W-1:0] prev_angle;
	logic [mftt_pkg::TURN_W-1:0]  prev_turn;
	logic [mftt_pkg::TURN_W-1:0]  new_turn;
	logic signed [DIFF_W-1:0]     diff;
	logic signed [DIFF_W-1:0]     thr_s;

	assign prev_angle = rd_valid_q ? rd_data_q[ENTRY_W-1:mftt_pkg::TURN_W] : '0;
	assign prev_turn  = rd_valid_q ? rd_data_q[mftt_pkg::TURN_W-1:0] : '0;
	assign diff  = $signed({2'b00, angle_q}) - $signed({2'b00, prev_angle});
	assign thr_s = $signed({2'b00, thr_q});

	always_comb begin
		priority if (diff > thr_s) begin
			new_turn = prev_turn - mftt_pkg::TURN_W'(1);
		end else if (diff < -thr_s) begin
			new_turn = prev_turn + mftt_pkg::TURN_W'(1);
		end else begin
			new_turn = prev_turn;
		end
	end

	assign wr_data = {angle_q, new_turn};

	// result registers
	logic done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.update;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			bus_out        <= bus_q;
			motor_slot     <= slot_q;
			angle          <= angle_q;
			previous_angle <= prev_angle;
			speed          <= speed_q;
			current        <= curr_q;
			temperature    <= temp_q;
			turn_count     <= new_turn;
		end
	end

	assign done = done_q;

endmodule

### rtl/motor_feedback_turn_tracker_unit.sv
// ----------------------------------------------------------------------------
// Motor feedback turn tracker
// Decodes CAN motor feedback frames and keeps a multi-turn count per slot.
// ----------------------------------------------------------------------------
// done rises once the request has passed the lookup and update states, with the
// result registered beside it; the result is taken while done is high.
// The single-port slot table is read, then written, so the block takes no new
// request while busy is high, through the lookup and update states.
// Requests outside the bus range or identifier window give no result.
// Reset clears the slot table at once through per-entry valid bits, and loads
// the configuration defaults; results cannot be stalled by the receiver.
module motor_feedback_turn_tracker_unit #(
	parameter int MOTORS_PER_BUS = mftt_pkg::MOTORS_PER_BUS_DEF,
	parameter int BUS_COUNT      = mftt_pkg::BUS_COUNT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                cfg_we,
	input  logic [mftt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mftt_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic [mftt_pkg::BUS_W-1:0]          bus_number,
	input  logic [mftt_pkg::FID_W-1:0]          frame_id,
	input  logic [mftt_pkg::PAYLOAD_W-1:0]      payload,
	output logic                                done,
	output logic [mftt_pkg::BUS_W-1:0]          bus_out,
	output logic [mftt_pkg::SLOT_OUT_W-1:0]     motor_slot,
	output logic [mftt_pkg::ANGLE_W-1:0]        angle,
	output logic [mftt_pkg::ANGLE_W-1:0]        previous_angle,
	output logic signed [mftt_pkg::SPEED_W-1:0] speed,
	output logic signed [mftt_pkg::CURR_W-1:0]  current,
	output logic [mftt_pkg::TEMP_W-1:0]         temperature,
	output logic signed [mftt_pkg::TURN_W-1:0]  turn_count
);

	mftt_pkg::ctrl_cmd_t  cmd;
	mftt_pkg::dp_status_t status;

	mftt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	mftt_dp #(
		.MOTORS_PER_BUS (MOTORS_PER_BUS),
		.BUS_COUNT      (BUS_COUNT)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.bus_number     (bus_number),
		.frame_id       (frame_id),
		.payload        (payload),
		.done           (done),
		.bus_out        (bus_out),
		.motor_slot     (motor_slot),
		.angle          (angle),
		.previous_angle (previous_angle),
		.speed          (speed),
		.current        (current),
		.temperature    (temperature),
		.turn_count     (turn_count)
	);

endmodule

### rtl/mftt_checker.sv
// ----------------------------------------------------------------------------
// Motor feedback turn tracker checker
// Port-level checks on request and result timing, bound to the top level.
// ----------------------------------------------------------------------------
module mftt_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	// a taken request always occupies the block in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted request did not raise busy");

	// a result only appears once its request has finished
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without preceding work");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

endmodule

bind motor_feedback_turn_tracker_unit mftt_checker u_mftt_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);

### test/tb.sv
// ----------------------------------------------------------------------------
// Motor feedback turn tracker testbench
// Drives CAN feedback frames through the start/busy port and tracks every
// motor slot in a local model. Each done strobe is checked field by field
// against the oldest predicted report. Directed frames cover the window edges
// and the turn thresholds. Random traffic then runs under several register
// settings, with random idle gaps between requests in all but one run.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mftt_pkg::*;

	localparam int SLOTS = MOTORS_PER_BUS_DEF * BUS_COUNT_DEF;

	typedef struct {
		logic [BUS_W-1:0]       bus;
		logic [SLOT_OUT_W-1:0]  slot;
		logic [ANGLE_W-1:0]     angle;
		logic [ANGLE_W-1:0]     prev_angle;
		logic signed [SPEED_W-1:0] speed;
		logic signed [CURR_W-1:0]  current;
		logic [TEMP_W-1:0]      temp;
		logic signed [TURN_W-1:0]  turns;
	} frame_result_t;

	logic                          clk;
	logic                          arst_n;
	logic                          start;
	logic                          busy;
	logic                          cfg_we;
	logic [CFG_IDX_W-1:0]          cfg_index;
	logic [CFG_DATA_W-1:0]         cfg_data;
	logic [BUS_W-1:0]              bus_number;
	logic [FID_W-1:0]              frame_id;
	logic [PAYLOAD_W-1:0]          payload;
	logic                          done;
	logic [BUS_W-1:0]              bus_out;
	logic [SLOT_OUT_W-1:0]         motor_slot;
	logic [ANGLE_W-1:0]            angle;
	logic [ANGLE_W-1:0]            previous_angle;
	logic signed [SPEED_W-1:0]     speed;
	logic signed [CURR_W-1:0]      current;
	logic [TEMP_W-1:0]             temperature;
	logic signed [TURN_W-1:0]      turn_count;

	// local copy of the slot table and the registers
	logic [ANGLE_W-1:0]  model_angle [SLOTS];
	logic [TURN_W-1:0]   model_turns [SLOTS];
	logic [FID_W-1:0]    cur_base;
	logic [THR_W-1:0]    cur_threshold;

	frame_result_t pending_reports [$];

	int errors;
	int frames_sent;
	int frames_hit;
	int reports_checked;
	int settings_used;

	motor_feedback_turn_tracker_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.bus_number    (bus_number),
		.frame_id      (frame_id),
		.payload       (payload),
		.done          (done),
		.bus_out       (bus_out),
		.motor_slot    (motor_slot),
		.angle         (angle),
		.previous_angle(previous_angle),
		.speed         (speed),
		.current       (current),
		.temperature   (temperature),
		.turn_count    (turn_count)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [PAYLOAD_W-1:0] pack_payload(input logic [15:0] ang,
			input logic [15:0] spd, input logic [15:0] cur, input logic [7:0] tmp);
		return {ang, spd, cur, tmp};
	endfunction

	// Update the local slot table for one frame; returns 1 when a report follows.
	function automatic bit track_frame(input logic [BUS_W-1:0] b, input logic [FID_W-1:0] f,
			input logic [PAYLOAD_W-1:0] p, output frame_result_t r);
		int slot;
		int pos;
		int diff;
		int limit;
		logic [ANGLE_W-1:0] now;
		r = '{default: '0};
		if (int'(b) >= BUS_COUNT_DEF)
			return 0;
		if (f < cur_base)
			return 0;
		slot = int'(f) - int'(cur_base);
		if (slot >= MOTORS_PER_BUS_DEF)
			return 0;
		pos = int'(b) * MOTORS_PER_BUS_DEF + slot;
		now = p[55:40];
		diff = int'(now) - int'(model_angle[pos]);
		limit = int'(cur_threshold);
		r.prev_angle = model_angle[pos];
		model_angle[pos] = now;
		if (diff > limit)
			model_turns[pos] = model_turns[pos] - 1;
		else if (diff < -limit)
			model_turns[pos] = model_turns[pos] + 1;
		r.bus = b;
		r.slot = slot[SLOT_OUT_W-1:0];
		r.angle = now;
		r.speed = p[39:24];
		r.current = p[23:8];
		r.temp = p[7:0];
		r.turns = model_turns[pos];
		return 1;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		frame_result_t want;
		if (arst_n && done !== 1'b0) begin
			if (pending_reports.size() == 0) begin
				$display("%0t: unexpected report, bus %0d slot %0d", $time, bus_out, motor_slot);
				errors++;
			end else begin
				want = pending_reports.pop_front();
				check_field("bus_out", want.bus, bus_out);
				check_field("motor_slot", want.slot, motor_slot);
				check_field("angle", want.angle, angle);
				check_field("previous_angle", want.prev_angle, previous_angle);
				check_field("speed", want.speed, speed);
				check_field("current", want.current, current);
				check_field("temperature", want.temp, temperature);
				check_field("turn_count", want.turns, turn_count);
				reports_checked++;
			end
		end
	end

	// Called at a clock edge; returns at the edge where the request was taken.
	task automatic send_frame(input logic [BUS_W-1:0] b, input logic [FID_W-1:0] f,
			input logic [PAYLOAD_W-1:0] p);
		frame_result_t r;
		start <= 1'b1;
		bus_number <= b;
		frame_id <= f;
		payload <= p;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		frames_sent++;
		if (track_frame(b, f, p, r)) begin
			pending_reports.push_back(r);
			frames_hit++;
		end
	endtask

	// Drop start for a random number of cycles, with junk on the fields.
	task automatic idle_gap(input bit quiet);
		int n;
		int r;
		n = 0;
		if (!quiet) begin
			r = $urandom_range(0, 99);
			if (r < 45)
				n = 0;
			else if (r < 85)
				n = $urandom_range(1, 3);
			else if (r < 97)
				n = $urandom_range(4, 10);
			else
				n = $urandom_range(20, 60);
		end
		if (n > 0) begin
			start <= 1'b0;
			for (int i = 0; i < n; i++) begin
				bus_number <= BUS_W'($urandom);
				frame_id <= FID_W'($urandom);
				payload <= PAYLOAD_W'({$urandom, $urandom});
				@(posedge clk);
			end
		end
	endtask

	// Hold off until every report is in, then let a missed request finish too.
	task automatic drain_reports();
		start <= 1'b0;
		@(posedge clk);
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_BASE_FRAME_ID)
			cur_base = d[FID_W-1:0];
		else if (idx == CFG_WRAP_THRESHOLD)
			cur_threshold = d[THR_W-1:0];
		@(posedge clk);
	endtask

	task automatic set_config(input logic [FID_W-1:0] base, input logic [THR_W-1:0] thr);
		// upper data bits are don't-care for the identifier register
		write_reg(CFG_BASE_FRAME_ID, {5'($urandom), base});
		write_reg(CFG_WRAP_THRESHOLD, thr);
		settings_used++;
	endtask

	task automatic test_reset_defaults();
		send_frame(2'd0, 11'd513, pack_payload(16'd0, 16'h1234, 16'h5678, 8'h9a));
		send_frame(2'd0, 11'd513, pack_payload(16'd5000, 16'h0001, 16'hffff, 8'h00));
		idle_gap(1'b0);
		send_frame(2'd0, 11'd513, pack_payload(16'd10001, 16'h7fff, 16'h8000, 8'h7f));
		send_frame(2'd0, 11'd513, pack_payload(16'd5000, 16'h8000, 16'h7fff, 8'h80));
		send_frame(2'd2, 11'd520, {PAYLOAD_W{1'b1}});
		send_frame(2'd1, 11'd516, pack_payload(16'h0000, 16'h8000, 16'h7fff, 8'hff));
		send_frame(2'd3, 11'd513, pack_payload(16'h4000, 16'h0, 16'h0, 8'h0));
		send_frame(2'd0, 11'd512, pack_payload(16'h4000, 16'h0, 16'h0, 8'h0));
		send_frame(2'd0, 11'd521, {PAYLOAD_W{1'b0}});
		drain_reports();
	endtask

	task automatic test_window_edges();
		// window starting at the top identifier, every jump counts
		set_config(11'd2047, 16'd0);
		send_frame(2'd1, 11'd2047, pack_payload(16'd0, 16'h0, 16'h0, 8'h0));
		send_frame(2'd1, 11'd2047, pack_payload(16'd1, 16'h0, 16'h0, 8'h1));
		send_frame(2'd1, 11'd2047, pack_payload(16'd0, 16'h0, 16'h0, 8'h2));
		send_frame(2'd0, 11'd2046, pack_payload(16'd9, 16'h0, 16'h0, 8'h3));
		drain_reports();
		// window at identifier zero, no jump can count
		set_config(11'd0, 16'hffff);
		send_frame(2'd2, 11'd0, pack_payload(16'hffff, 16'h0, 16'h0, 8'h0));
		send_frame(2'd2, 11'd0, pack_payload(16'h0000, 16'h0, 16'h0, 8'h0));
		send_frame(2'd0, 11'd7, pack_payload(16'd1234, 16'h4321, 16'hbeef, 8'h55));
		send_frame(2'd0, 11'd8, pack_payload(16'd1234, 16'h4321, 16'hbeef, 8'h55));
		drain_reports();
	endtask

	task automatic test_random_traffic(input logic [FID_W-1:0] base,
			input logic [THR_W-1:0] thr, input int item_goal, input bit quiet,
			input bit with_pauses);
		int goal;
		int r;
		int slot;
		logic [BUS_W-1:0] b;
		logic [FID_W-1:0] f;
		logic [ANGLE_W-1:0] prev;
		logic [ANGLE_W-1:0] next;
		set_config(base, thr);
		goal = frames_sent + item_goal;
		while (frames_sent < goal) begin
			b = BUS_W'($urandom_range(0, BUS_COUNT_DEF - 1));
			slot = $urandom_range(0, MOTORS_PER_BUS_DEF - 1);
			f = FID_W'(int'(cur_base) + slot);
			prev = model_angle[int'(b) * MOTORS_PER_BUS_DEF + slot];
			// aim the angle at the threshold boundaries most of the time
			case ($urandom_range(0, 5))
				0: next = ANGLE_W'($urandom);
				1: next = prev + ANGLE_W'($urandom_range(0, 200)) - 16'd100;
				2: next = prev + cur_threshold;
				3: next = prev - cur_threshold;
				4: next = prev + cur_threshold + 16'd1;
				default: next = prev - cur_threshold - 16'd1;
			endcase
			r = $urandom_range(0, 99);
			if (r < 8)
				b = 2'd3;
			else if (r < 16)
				f = FID_W'($urandom);
			send_frame(b, f, pack_payload(next, 16'($urandom), 16'($urandom), 8'($urandom)));
			if (with_pauses && $urandom_range(0, 39) == 0)
				drain_reports();
			else
				idle_gap(quiet);
		end
		drain_reports();
	endtask

	initial begin
		#(2_000_000);
		$display("tb: failure");
		$finish;
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		bus_number = '0;
		frame_id = '0;
		payload = '0;
		errors = 0;
		frames_sent = 0;
		frames_hit = 0;
		reports_checked = 0;
		settings_used = 1;
		cur_base = BASE_FRAME_ID_RST;
		cur_threshold = WRAP_THRESHOLD_RST;
		for (int i = 0; i < SLOTS; i++) begin
			model_angle[i] = '0;
			model_turns[i] = '0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_window_edges();
		test_random_traffic(11'd513, 16'd5000, 250, 1'b0, 1'b1);
		test_random_traffic(11'd0, 16'd0, 200, 1'b1, 1'b0);
		test_random_traffic(11'd2047, 16'hffff, 150, 1'b0, 1'b0);
		test_random_traffic(11'd2040, 16'd1, 200, 1'b0, 1'b1);
		test_random_traffic(FID_W'($urandom), THR_W'($urandom), 300, 1'b0, 1'b0);
		test_random_traffic(FID_W'($urandom), 16'd30000, 230, 1'b0, 1'b0);

		$display("tb: %0d frames sent, %0d slot updates checked, %0d register settings",
			frames_sent, reports_checked, settings_used);
		if (errors == 0 && pending_reports.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
